/* design/graph_adjacency_connectivity_unit_macros.svh */
// Assertion macros for the graph adjacency connectivity unit.
// Included by the top level; depends on nothing else.
`ifndef GRAPH_ADJACENCY_CONNECTIVITY_UNIT_MACROS_SVH
`define GRAPH_ADJACENCY_CONNECTIVITY_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GAC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GAC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* design/gac_pkg.sv */
// Shared types and codes for the graph adjacency connectivity unit.
// No dependencies; imported by every module of the block.
package gac_pkg;

   localparam int NODE_W  = 6;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      FUNC_SET    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_CHECK  = 2'd3
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
   } req_word_type;

   typedef struct packed {
      logic edge_present;
      logic connected;
      logic status;
   } rsp_word_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_A,
      ST_ROW_B,
      ST_SEARCH,
      ST_REPLY
   } gac_state_type;

endpackage

/* design/gac_adj_mem.sv */
// Adjacency row memory: one synchronous read port, one write port.
// Per-row valid bits give an all-zero matrix after reset or clear; uses gac_pkg.
module gac_adj_mem
   import gac_pkg::*;
#(
   parameter int MAX_NODES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  mem_ctl_type                  mem_ctl,
   input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
   input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
   input  logic [MAX_NODES-1:0]         wr_data,
   output logic [MAX_NODES-1:0]         rd_row
);

   logic [MAX_NODES-1:0] adj_ram [MAX_NODES];
   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 rd_valid_ff, rd_valid_in;
   logic [MAX_NODES-1:0] row_valid_ff, row_valid_in;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         adj_ram[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= adj_ram[rd_addr];
      end
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      rd_valid_in  = rd_valid_ff;
      if (clear) begin
         row_valid_in = '0;
      end else if (mem_ctl.wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
      if (mem_ctl.rd_en) begin
         rd_valid_in = row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   // a row never written since the last clear reads as empty
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* design/gac_ctrl.sv */
// Sequencer: edge read-modify-write and row-by-row reachability sweep.
// Drives gac_adj_mem through mem_ctl_type; uses gac_pkg.
module gac_ctrl
   import gac_pkg::*;
#(
   parameter int MAX_NODES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(MAX_NODES+1)-1:0] node_limit,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  req_word_type                   req_word,
   input  logic                           out_free,
   output logic                           rsp_load,
   output rsp_word_type                   rsp_result,
   output mem_ctl_type                    mem_ctl,
   output logic [$clog2(MAX_NODES)-1:0]   rd_addr,
   output logic [$clog2(MAX_NODES)-1:0]   wr_addr,
   output logic [MAX_NODES-1:0]           wr_data,
   input  logic [MAX_NODES-1:0]           rd_row
);

   localparam int AW   = $clog2(MAX_NODES);
   localparam int CW   = $clog2(MAX_NODES+1);
   localparam int CMPW = (CW > NODE_W) ? CW : NODE_W;

   gac_state_type        state_ff, state_in;
   func_type             func_ff, func_in;
   logic [AW-1:0]        a_ff, a_in, b_ff, b_in, idx_ff, idx_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in, frontier_ff, frontier_in;
   rsp_word_type         result_ff, result_in;

   logic                 a_oor, b_oor, small_graph, last_row;
   logic [MAX_NODES-1:0] in_use;

   assign a_oor       = CMPW'(req_word.node_a) >= CMPW'(node_limit);
   assign b_oor       = CMPW'(req_word.node_b) >= CMPW'(node_limit);
   assign small_graph = node_limit <= CW'(1);
   assign last_row    = (CW'(idx_ff) + CW'(1)) == node_limit;

   always_comb begin
      for (int j = 0; j < MAX_NODES; j++) begin
         in_use[j] = CW'(j) < node_limit;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_word.func == FUNC_CHECK) begin
                  state_in = small_graph ? ST_REPLY : ST_SEARCH;
               end else if (a_oor || b_oor) begin
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_ROW_A;
               end
            end
         end
         ST_ROW_A: begin
            state_in = (func_ff == FUNC_QUERY || a_ff == b_ff) ? ST_REPLY : ST_ROW_B;
         end
         ST_ROW_B: begin
            state_in = ST_REPLY;
         end
         ST_SEARCH: begin
            if (frontier_in == '0) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      mem_ctl     = '0;
      rd_addr     = '0;
      wr_addr     = a_ff;
      wr_data     = rd_row;
      func_in     = func_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      idx_in      = idx_ff;
      visited_in  = visited_ff;
      frontier_in = frontier_ff;
      result_in   = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in   = req_word.func;
               a_in      = AW'(req_word.node_a);
               b_in      = AW'(req_word.node_b);
               result_in = '0;
               if (req_word.func == FUNC_CHECK) begin
                  if (small_graph) begin
                     result_in.connected = 1'b1;
                  end else begin
                     // seed the sweep at vertex 0
                     visited_in    = MAX_NODES'(1);
                     frontier_in   = MAX_NODES'(1);
                     idx_in        = '0;
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = '0;
                  end
               end else if (a_oor || b_oor) begin
                  result_in.status = 1'b1;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = a_in;
               end
            end
         end
         ST_ROW_A: begin
            if (func_ff == FUNC_QUERY) begin
               result_in.edge_present = rd_row[b_ff];
            end else begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = a_ff;
               wr_data[b_ff] = (func_ff == FUNC_SET);
               if (a_ff != b_ff) begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = b_ff;
               end
            end
         end
         ST_ROW_B: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = b_ff;
            wr_data[a_ff] = (func_ff == FUNC_SET);
         end
         ST_SEARCH: begin
            // expand this row only if it is on the frontier
            if (frontier_ff[idx_ff]) begin
               visited_in          = visited_ff | rd_row;
               frontier_in         = frontier_ff | (rd_row & ~visited_ff);
               frontier_in[idx_ff] = 1'b0;
            end
            if (frontier_in == '0) begin
               result_in.connected = &(visited_in | ~in_use);
            end else begin
               idx_in        = last_row ? '0 : idx_ff + AW'(1);
               mem_ctl.rd_en = 1'b1;
               rd_addr       = idx_in;
            end
         end
         ST_REPLY: begin
            rsp_load = out_free;
         end
      endcase
   end

   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      idx_ff      <= idx_in;
      visited_ff  <= visited_in;
      frontier_ff <= frontier_in;
      result_ff   <= result_in;
   end

endmodule

/* design/graph_adjacency_connectivity_unit.sv */
// Top level of the graph adjacency connectivity unit: ports, count register,
// result register. Uses gac_pkg, gac_adj_mem, gac_ctrl and the macros header.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_ready  req_word_type  (func, node_a, node_b)
//   rsp      out        rsp_valid/rsp_ready  rsp_word_type  (edge_present, connected, status)
//   csr      in         csr_wr_en            csr_wr_data    (node_count)
//
// One word is in work at a time. An out-of-range vertex goes straight to the reply
// step; a query reads row node_a; set/remove reads and rewrites row node_a and,
// unless it is a self loop, row node_b; connectivity with fewer than two vertices
// goes straight to the reply step, else the sweep reads one adjacency row per cycle.
// Reset and every node_count write clear the matrix (per-row valid bits). A
// finished word waits in the result register; the sequencer holds its reply
// step while that register is full and not being drained.
`include "graph_adjacency_connectivity_unit_macros.svh"

module graph_adjacency_connectivity_unit
   import gac_pkg::*;
#(
   parameter int MAX_NODES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_word_type       rsp_word
);

   localparam int AW   = $clog2(MAX_NODES);
   localparam int CW   = $clog2(MAX_NODES+1);
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [CW-1:0]        node_limit_ff, node_limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;
   logic                 out_free, rsp_load;
   rsp_word_type         rsp_result;
   mem_ctl_type          mem_ctl;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [MAX_NODES-1:0] wr_data, rd_row;

   // clip the vertex count to the matrix size on write
   always_comb begin
      node_limit_in = node_limit_ff;
      if (csr_wr_en) begin
         node_limit_in = (CMPW'(csr_wr_data) > CMPW'(MAX_NODES)) ?
                         CW'(MAX_NODES) : CW'(csr_wr_data);
      end
   end

   // result register: load when free or draining, drop when taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = rsp_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_limit_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_limit_ff <= node_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   gac_adj_mem #(
      .MAX_NODES (MAX_NODES)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_wr_en),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_row  (rd_row)
   );

   gac_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .node_limit (node_limit_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .out_free   (out_free),
      .rsp_load   (rsp_load),
      .rsp_result (rsp_result),
      .mem_ctl    (mem_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_row     (rd_row)
   );

   // one word in work at a time
   `GAC_ASSERT_NEXT(a_single_word, clock, reset, req_valid && req_ready, !req_ready)
   // never overwrite a result that is still waiting
   `GAC_ASSERT_IMPL(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready)
   // an error result carries no edge or connectivity answer
   `GAC_ASSERT_IMPL(a_error_clean, clock, reset, rsp_valid && rsp_word.status,
                    !rsp_word.edge_present && !rsp_word.connected)

endmodule
